@@ hdl/counting_semaphore_fifo_waiters_top_defines.svh @@
// Assertion helpers shared by the semaphore bank.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSFW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/csfw_pkg.sv @@
package csfw_pkg;

   // Operation codes of an input item.
   localparam logic [1:0] OP_SEM_OP   = 2'd0;
   localparam logic [1:0] OP_SET_VAL  = 2'd1;
   localparam logic [1:0] OP_GET_VAL  = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_GRANTED = 3'd0,
      KIND_BLOCKED = 3'd1,
      KIND_WOKEN   = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_READ    = 3'd4,
      KIND_BAD_IDX = 3'd5,
      KIND_FULL    = 3'd6,
      KIND_BAD_OP  = 3'd7
   } kind_type;

   localparam logic signed [15:0] VALUE_MAX = 16'sd32767;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         sem_sel;
      logic signed [15:0] amount;
      logic [5:0]         requester_id;
      logic signed [15:0] new_value;
      logic               batch_last;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [5:0]         who;
      logic signed [15:0] data;
      logic               batch_end;
      logic               last;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WAKE = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

endpackage

@@ hdl/counting_semaphore_fifo_waiters_top.sv @@
// A bank of counting semaphores, each with a FIFO of blocked requesters.
// An item is transferred when start is high and busy is low. A bad opcode
// or bad index is answered in the next cycle with busy staying low. Any other
// item has the semaphore state memory read, then written back where the item
// changes it. A signal that wakes waiters reads one entry of the waiter memory
// for each wake and then gives a final done result. Every result is shown for
// one cycle with rsp_strobe high and cannot be held off; the last result of
// an item carries last set. Results of one item come on consecutive cycles.
`include "counting_semaphore_fifo_waiters_top_defines.svh"

module counting_semaphore_fifo_waiters_top
   import csfw_pkg::*;
#(
   parameter int NUM_SEMS    = 16,
   parameter int MAX_WAITERS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   localparam int IW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int HW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CW = $clog2(MAX_WAITERS + 1);
   localparam int WD = NUM_SEMS * MAX_WAITERS;
   localparam int AW = (WD > 1) ? $clog2(WD) : 1;

   typedef struct packed {
      logic signed [15:0] value;
      logic [HW-1:0]      head;
      logic [CW-1:0]      count;
   } sem_entry_type;

   typedef struct packed {
      logic [5:0]  who;
      logic [15:0] want;
   } waiter_type;

   // Memories.
   sem_entry_type st_mem [NUM_SEMS];
   waiter_type    wt_mem [WD];

   sem_entry_type st_rd_ff, st_wd;
   logic [IW-1:0] st_ra;
   logic          st_we;
   waiter_type    wt_rd_ff, wt_wd;
   logic [AW-1:0] wt_ra, wt_wa;
   logic          wt_we;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic signed [15:0] val_ff, val_in;
   logic [HW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic [4:0]         sem_count_ff;
   logic [NUM_SEMS-1:0] sem_valid_ff;

   logic               accept;
   logic               idx_ok;
   logic [IW-1:0]      idx;
   sem_entry_type      cur;
   logic signed [16:0] want_s;
   logic signed [16:0] sum_s;
   logic signed [15:0] sat_v;
   logic [HW:0]        slot_sum;
   logic [HW-1:0]      slot;
   logic [HW-1:0]      head_next;
   logic signed [16:0] wake_want;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
   assign idx        = req_ff.sem_sel[IW-1:0];
   assign st_ra      = req_payload.sem_sel[IW-1:0];

   // Range check of an incoming index.
   assign idx_ok = ({3'b0, req_payload.sem_sel} < {6'b0, sem_count_ff}) &&
                   (32'(req_payload.sem_sel) < NUM_SEMS);

   // An entry never written reads as all zero.
   always_comb begin
      cur = sem_valid_ff[idx] ? st_rd_ff : '0;
   end

   // Datapath helpers.
   assign want_s    = -{req_ff.amount[15], req_ff.amount};
   assign sum_s     = {cur.value[15], cur.value} + {req_ff.amount[15], req_ff.amount};
   assign sat_v     = (sum_s > 17'sd32767) ? VALUE_MAX : sum_s[15:0];
   assign slot_sum  = (HW+1)'(cur.head) + (HW+1)'(cur.count);
   assign slot      = (slot_sum >= (HW+1)'(MAX_WAITERS)) ?
                      HW'(slot_sum - (HW+1)'(MAX_WAITERS)) : slot_sum[HW-1:0];
   assign head_next = (head_ff == HW'(MAX_WAITERS - 1)) ? '0 : head_ff + HW'(1);
   assign wake_want = $signed({1'b0, wt_rd_ff.want});
   assign wt_wa     = AW'(idx) * AW'(MAX_WAITERS) + AW'(slot);
   assign wt_wd     = '{who: req_ff.requester_id, want: want_s[15:0]};

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{kind: KIND_DONE, who: '0, data: '0, batch_end: req_ff.batch_last,
                        last: 1'b1};
      st_we         = 1'b0;
      st_wd         = '{value: val_ff, head: head_ff, count: count_ff};
      wt_we         = 1'b0;
      wt_ra         = AW'(idx) * AW'(MAX_WAITERS) + AW'(head_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               if (req_payload.opcode == OP_RESERVED) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{kind: KIND_BAD_OP, who: req_payload.requester_id, data: '0,
                             batch_end: req_payload.batch_last, last: 1'b1};
               end else if (!idx_ok) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{kind: KIND_BAD_IDX, who: req_payload.requester_id, data: '0,
                             batch_end: req_payload.batch_last, last: 1'b1};
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            val_in        = sat_v;
            head_in       = cur.head;
            count_in      = cur.count;
            wt_ra         = AW'(idx) * AW'(MAX_WAITERS) + AW'(cur.head);
            priority if (req_ff.opcode == OP_SET_VAL) begin
               st_we = 1'b1;
               st_wd = '{value: req_ff.new_value, head: cur.head, count: cur.count};
            end else if (req_ff.opcode == OP_GET_VAL) begin
               rsp_in.kind = KIND_READ;
               rsp_in.data = cur.value;
            end else if (req_ff.amount < 0) begin
               rsp_in.who = req_ff.requester_id;
               if ($signed({cur.value[15], cur.value}) >= want_s) begin
                  st_we = 1'b1;
                  st_wd = '{value: 16'(({cur.value[15], cur.value}) - want_s),
                            head: cur.head, count: cur.count};
                  rsp_in.kind = KIND_GRANTED;
               end else if (cur.count >= CW'(MAX_WAITERS)) begin
                  rsp_in.kind = KIND_FULL;
               end else begin
                  st_we = 1'b1;
                  st_wd = '{value: cur.value, head: cur.head, count: cur.count + CW'(1)};
                  wt_we = 1'b1;
                  rsp_in.kind = KIND_BLOCKED;
               end
            end else if (req_ff.amount > 0) begin
               if (cur.count == '0) begin
                  st_we = 1'b1;
                  st_wd = '{value: sat_v, head: cur.head, count: cur.count};
               end else begin
                  rsp_strobe_in = 1'b0;
                  state_in      = ST_WAKE;
               end
            end else begin
               rsp_in.kind = KIND_DONE;
            end
         end
         ST_WAKE: begin
            rsp_strobe_in = 1'b1;
            if (wake_want > $signed({val_ff[15], val_ff})) begin
               st_we    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rsp_in   = '{kind: KIND_WOKEN, who: wt_rd_ff.who, data: wt_rd_ff.want,
                            batch_end: 1'b0, last: 1'b0};
               val_in   = 16'({val_ff[15], val_ff} - wake_want);
               head_in  = head_next;
               count_in = count_ff - CW'(1);
               wt_ra    = AW'(idx) * AW'(MAX_WAITERS) + AW'(head_next);
               if (count_ff == CW'(1)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            st_we         = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State memory: one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[idx] <= st_wd;
      end
      st_rd_ff <= st_mem[st_ra];
   end

   // Waiter memory.
   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_wa] <= wt_wd;
      end
      wt_rd_ff <= wt_mem[wt_ra];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         sem_count_ff  <= 5'd16;
         sem_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            sem_count_ff <= csr_wr_data;
         end
         if (st_we) begin
            sem_valid_ff[idx] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      val_ff   <= val_in;
      head_ff  <= head_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   `CSFW_ASSERT_NOW(a_wake_nonempty, state_ff == ST_WAKE, count_ff != '0, "wake with empty queue")
   `CSFW_ASSERT_NOW(a_not_last_is_woken, rsp_strobe && !rsp_payload.last, rsp_payload.kind == KIND_WOKEN, "non-final result is not a wake")
   `CSFW_ASSERT_NEXT(a_accept_progress, accept, rsp_strobe || busy, "accepted item left no trace")
   `CSFW_ASSERT_NEXT(a_busy_ends_last, busy && state_in == ST_IDLE, rsp_strobe && rsp_payload.last, "item ended without a final result")

endmodule
